// File: sv/decoder_cv_store_assert.svh
// Assertion macros used by the checker file of the CV store.
`ifndef DECODER_CV_STORE_ASSERT_SVH
`define DECODER_CV_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/dcs_pkg.sv
// Package with the constants and types of the CV store.
`default_nettype none
package dcs_pkg;

   // Highest CV number and the store that follows from it.
   localparam int MAX_CV    = 2048;
   localparam int CV_DEPTH  = MAX_CV + 1;
   localparam int CV_AW     = $clog2(CV_DEPTH);
   localparam int ADDR_W    = 12;
   localparam int BYTE_W    = 8;
   localparam int CONFIG_CV = 29;

   // Operation codes.
   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_VERIFY = 2'd2;

   // Addressing modes.
   localparam logic [1:0] SP_REGISTER = 2'd0;
   localparam logic [1:0] SP_PAGE     = 2'd1;
   localparam logic [1:0] SP_CV       = 2'd2;
   localparam logic [1:0] SP_BIT      = 2'd3;

   // Register numbers with a special mapping.
   localparam logic [ADDR_W-1:0] REG_CONFIG = 12'd5;
   localparam logic [ADDR_W-1:0] REG_PAGE   = 12'd6;

   // Bounds of the register map; the low registers also restore page one.
   localparam logic [ADDR_W-1:0] REG_MIN     = 12'd1;
   localparam logic [ADDR_W-1:0] REG_LOW_MAX = 12'd4;
   localparam logic [ADDR_W-1:0] REG_MAX     = 12'd8;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   // Request as held during execution.
   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        space;
      logic [3:0]        bit_index;
      logic [BYTE_W-1:0] data;
      logic              addr_ok;
      logic              page_tgt;
      logic              page_one;
   } req_type;

   // What the modify unit decides for one request.
   typedef struct packed {
      logic              wr_en;
      logic [BYTE_W-1:0] wr_data;
      logic [BYTE_W-1:0] value;
      logic              failed;
   } alu_out_type;

endpackage
`default_nettype wire

// File: sv/dcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/dcs_alu.sv
// Modify and compare unit: works out get, set and verify on one byte or bit.
`default_nettype none
module dcs_alu (
   input  wire dcs_pkg::req_type             req,
   input  wire logic [dcs_pkg::BYTE_W-1:0]   cur,
   output dcs_pkg::alu_out_type              res
);

   logic                       bit_ok;
   logic                       cur_bit;
   logic                       data_is_bit;
   logic [dcs_pkg::BYTE_W-1:0] mask;
   logic [dcs_pkg::BYTE_W-1:0] bit_new;

   // Bit-mode helpers.
   assign bit_ok      = !req.bit_index[3];
   assign cur_bit     = cur[req.bit_index[2:0]];
   assign data_is_bit = (req.data[dcs_pkg::BYTE_W-1:1] == '0);
   assign mask        = dcs_pkg::BYTE_W'(1) << req.bit_index[2:0];
   assign bit_new     = req.data[0] ? (cur | mask) : (cur & ~mask);

   // Decide the outcome; a failed request writes nothing and reports zero.
   always_comb begin
      res = '0;
      if (!req.addr_ok) begin
         res.failed = 1'b1;
      end else if (req.space == dcs_pkg::SP_BIT) begin
         if (!bit_ok) begin
            res.failed = 1'b1;
         end else begin
            unique case (req.op)
               dcs_pkg::OP_GET: begin
                  res.value = {{(dcs_pkg::BYTE_W-1){1'b0}}, cur_bit};
               end
               dcs_pkg::OP_SET: begin
                  if (data_is_bit) begin
                     res.wr_en   = 1'b1;
                     res.wr_data = bit_new;
                     res.value   = req.data;
                  end else begin
                     res.failed = 1'b1;
                  end
               end
               dcs_pkg::OP_VERIFY: begin
                  if ({{(dcs_pkg::BYTE_W-1){1'b0}}, cur_bit} == req.data) begin
                     res.value = req.data;
                  end else begin
                     res.failed = 1'b1;
                  end
               end
               default: begin
                  res.failed = 1'b1;
               end
            endcase
         end
      end else begin
         unique case (req.op)
            dcs_pkg::OP_GET: begin
               res.value = cur;
            end
            dcs_pkg::OP_SET: begin
               res.wr_en   = 1'b1;
               res.wr_data = req.data;
               res.value   = req.data;
            end
            dcs_pkg::OP_VERIFY: begin
               if (cur == req.data) begin
                  res.value = req.data;
               end else begin
                  res.failed = 1'b1;
               end
            end
            default: begin
               res.failed = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: sv/decoder_cv_store.sv
// Top level of the decoder CV store serving service-mode requests.
//
// A request is taken when start is high and busy is low. It is done in
// order: first the registered read of the byte memory, then the shared
// modify and compare unit runs and a set writes the byte back. The
// result appears on rsp_read_value and rsp_failed for exactly one cycle with
// rsp_valid high, in the cycle after that; the receiver cannot stall it, so
// it must take the transfer in that cycle. busy is already low in the strobe
// cycle, so a new request may start there; no request is taken while one
// is in flight. After reset the memory is cleared one byte per cycle, all
// MAX_CV + 1 bytes (2049 at the default size), with busy high.
`default_nettype none
module decoder_cv_store (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [1:0]  req_space,
   input  wire logic [11:0] req_cv_address,
   input  wire logic [3:0]  req_bit_index,
   input  wire logic [7:0]  req_data_value,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_value,
   output logic             rsp_failed
);

   dcs_pkg::state_type          state_ff, state_in;
   logic [dcs_pkg::CV_AW-1:0]   clr_ff, clr_in;
   dcs_pkg::req_type            req_ff, req_in;
   logic [dcs_pkg::CV_AW-1:0]   addr_ff, addr_in;
   logic [dcs_pkg::BYTE_W-1:0]  page_ff, page_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dcs_pkg::BYTE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                        rsp_failed_ff, rsp_failed_in;

   logic                        accept;
   logic                        reg_ok;
   logic                        cv_ok;
   logic                        is_reg;
   logic [dcs_pkg::CV_AW-1:0]   rd_addr;
   logic [dcs_pkg::CV_AW-1:0]   wr_addr;
   logic [dcs_pkg::BYTE_W-1:0]  wr_data;
   logic                        wr_en;
   logic [dcs_pkg::BYTE_W-1:0]  ram_rd_data;
   logic [dcs_pkg::BYTE_W-1:0]  cur;
   dcs_pkg::alu_out_type        alu_res;

   assign busy   = (state_ff != dcs_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Address checks and mapping, done on the request ports at the transfer.
   assign is_reg = (req_space == dcs_pkg::SP_REGISTER);
   assign reg_ok = (req_cv_address >= dcs_pkg::REG_MIN) && (req_cv_address <= dcs_pkg::REG_MAX);
   assign cv_ok  = (req_cv_address <= dcs_pkg::ADDR_W'(dcs_pkg::MAX_CV));

   always_comb begin
      if (is_reg) begin
         if (req_cv_address == dcs_pkg::REG_CONFIG) begin
            rd_addr = dcs_pkg::CV_AW'(dcs_pkg::CONFIG_CV);
         end else begin
            rd_addr = dcs_pkg::CV_AW'(req_cv_address[3:0]);
         end
      end else if (cv_ok) begin
         rd_addr = req_cv_address[dcs_pkg::CV_AW-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   // Byte memory.
   dcs_ram #(
      .WIDTH (dcs_pkg::BYTE_W),
      .DEPTH (dcs_pkg::CV_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared modify and compare unit; the page register stands in for register 6.
   assign cur = req_ff.page_tgt ? page_ff : ram_rd_data;

   dcs_alu u_alu (
      .req (req_ff),
      .cur (cur),
      .res (alu_res)
   );

   // Write port: the clearing pass, or the write-back of a set to the address it read.
   always_comb begin
      if (state_ff == dcs_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == dcs_pkg::ST_EXEC) && alu_res.wr_en && !req_ff.page_tgt;
         wr_addr = addr_ff;
         wr_data = alu_res.wr_data;
      end
   end

   // Sequencer and request capture.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      page_in       = page_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_failed_in = rsp_failed_ff;
      unique case (state_ff)
         dcs_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == dcs_pkg::CV_AW'(dcs_pkg::MAX_CV)) begin
               state_in = dcs_pkg::ST_IDLE;
            end
         end
         dcs_pkg::ST_IDLE: begin
            if (accept) begin
               req_in.op        = req_func;
               req_in.space     = req_space;
               req_in.bit_index = req_bit_index;
               req_in.data      = req_data_value;
               req_in.addr_ok   = is_reg ? reg_ok : cv_ok;
               req_in.page_tgt  = is_reg && (req_cv_address == dcs_pkg::REG_PAGE);
               req_in.page_one  = is_reg && reg_ok
                                  && (req_cv_address <= dcs_pkg::REG_LOW_MAX)
                                  && (req_func <= dcs_pkg::OP_VERIFY);
               addr_in          = rd_addr;
               state_in         = dcs_pkg::ST_EXEC;
            end
         end
         dcs_pkg::ST_EXEC: begin
            if (req_ff.page_tgt && alu_res.wr_en) begin
               page_in = alu_res.wr_data;
            end else if (req_ff.page_one) begin
               page_in = dcs_pkg::BYTE_W'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_value_in  = alu_res.value;
            rsp_failed_in = alu_res.failed;
            state_in      = dcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = dcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         page_ff      <= dcs_pkg::BYTE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_failed     = rsp_failed_ff;

endmodule
`default_nettype wire

// File: sv/decoder_cv_store_checker.sv
// Port-level checker for the CV store, bound to the top level.
`default_nettype none
`include "decoder_cv_store_assert.svh"
module decoder_cv_store_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_read_value,
   input wire logic       rsp_failed
);

   // A failed result carries a zero value.
   `DCS_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_failed, rsp_read_value == 8'd0, "failed result with nonzero value")

   // Every accepted request is followed by its result strobe.
   `DCS_ASSERT_NOW(a_result_lat, clock, reset, start && !busy, ##2 rsp_valid, "missing result after a request")

   // The block is busy in the cycle after it takes a request.
   `DCS_ASSERT_NEXT(a_busy_after, clock, reset, start && !busy, busy, "not busy after a request")

   // A result strobe is never repeated back to back.
   `DCS_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")

endmodule

bind decoder_cv_store decoder_cv_store_checker u_checker (.*);
`default_nettype wire

// File: tb/decoder_cv_store_test.sv
// Self-checking testbench for the decoder CV store: directed and random service-mode requests.
module decoder_cv_store_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dcs_pkg::*;

   // Operation code with no meaning, and the register numbers that bound the map.
   localparam logic [1:0]        OP_UNUSED   = 2'd3;
   localparam logic [ADDR_W-1:0] REG_FIRST   = 12'd1;
   localparam logic [ADDR_W-1:0] REG_LOW_END = 12'd4;
   localparam logic [ADDR_W-1:0] REG_LAST    = 12'd8;
   localparam int                BIT_LIMIT   = 8;
   localparam int                RANDOM_ITEMS = 700;
   localparam int                DRAIN_CYCLES = 8;

   // Store copies: one follows the planned stimulus, one follows accepted transfers.
   localparam int PLAN_COPY  = 0;
   localparam int CHECK_COPY = 1;

   typedef struct packed {
      logic [1:0]        func;
      logic [1:0]        space;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        bit_pos;
      logic [BYTE_W-1:0] data;
   } command_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              failed;
   } answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_func = '0;
   logic [1:0]        req_space = '0;
   logic [11:0]       req_cv_address = '0;
   logic [3:0]        req_bit_index = '0;
   logic [7:0]        req_data_value = '0;
   logic              rsp_valid;
   logic [7:0]        rsp_read_value;
   logic              rsp_failed;

   logic [BYTE_W-1:0] cv_mem [0:1][0:MAX_CV];
   logic [BYTE_W-1:0] page_reg [0:1];

   command_type pending_cmds[$];
   answer_type  expected_answers[$];
   int          items_total;
   int          directed_total;
   int          accepted_count;
   int          answer_count;
   int          failed_count;
   int          error_count;

   decoder_cv_store dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_space      (req_space),
      .req_cv_address (req_cv_address),
      .req_bit_index  (req_bit_index),
      .req_data_value (req_data_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_failed     (rsp_failed)
   );

   // Clock and a single reset pulse.
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Current content of the byte, bit or register that a command addresses.
   function automatic logic [BYTE_W-1:0] cell_value(int copy, command_type c);
      logic [BYTE_W-1:0] v;
      v = '0;
      case (c.space)
         SP_REGISTER: begin
            if (c.addr == REG_PAGE)
               v = page_reg[copy];
            else if (c.addr == REG_CONFIG)
               v = cv_mem[copy][CONFIG_CV];
            else if (c.addr >= REG_FIRST && c.addr <= REG_LAST)
               v = cv_mem[copy][c.addr];
         end
         SP_BIT: begin
            if (c.addr <= MAX_CV && c.bit_pos < BIT_LIMIT)
               v = {7'b0, cv_mem[copy][c.addr][c.bit_pos[2:0]]};
         end
         default: begin
            if (c.addr <= MAX_CV)
               v = cv_mem[copy][c.addr];
         end
      endcase
      return v;
   endfunction

   // Executes one command on a store copy and returns the answer it yields.
   function automatic answer_type execute_command(int copy, command_type c);
      logic [BYTE_W-1:0] cur;
      logic [BYTE_W-1:0] val;
      logic              target_ok;
      logic              ok;
      answer_type        a;
      cur = cell_value(copy, c);
      val = '0;
      ok = 1'b0;
      case (c.space)
         SP_REGISTER: target_ok = (c.addr >= REG_FIRST && c.addr <= REG_LAST);
         SP_BIT:      target_ok = (c.addr <= MAX_CV && c.bit_pos < BIT_LIMIT);
         default:     target_ok = (c.addr <= MAX_CV);
      endcase
      if (c.func != OP_UNUSED && target_ok) begin
         // Any access to registers one to four restores page one first.
         if (c.space == SP_REGISTER && c.addr <= REG_LOW_END)
            page_reg[copy] = 8'd1;
         case (c.func)
            OP_GET: begin
               ok = 1'b1;
               val = cur;
            end
            OP_SET: begin
               if (!(c.space == SP_BIT && c.data > 8'd1)) begin
                  ok = 1'b1;
                  val = c.data;
                  case (c.space)
                     SP_REGISTER: begin
                        if (c.addr == REG_PAGE)
                           page_reg[copy] = c.data;
                        else if (c.addr == REG_CONFIG)
                           cv_mem[copy][CONFIG_CV] = c.data;
                        else
                           cv_mem[copy][c.addr] = c.data;
                     end
                     SP_BIT:  cv_mem[copy][c.addr][c.bit_pos[2:0]] = c.data[0];
                     default: cv_mem[copy][c.addr] = c.data;
                  endcase
               end
            end
            default: begin
               val = c.data;
               ok = (cur == c.data);
            end
         endcase
      end
      a.value = ok ? val : '0;
      a.failed = !ok;
      return a;
   endfunction

   // Queues a command and advances the planning copy so later verifies can match.
   task automatic plan(logic [1:0] f, logic [1:0] sp, logic [ADDR_W-1:0] a,
                       logic [3:0] b, logic [BYTE_W-1:0] d);
      command_type c;
      answer_type  unused_answer;
      c = '{func: f, space: sp, addr: a, bit_pos: b, data: d};
      unused_answer = execute_command(PLAN_COPY, c);
      pending_cmds.push_back(c);
   endtask

   // Random command aimed at a few busy CVs, with a share of bad requests.
   function automatic command_type random_command();
      command_type c;
      int          pick;
      pick = $urandom_range(99, 0);
      c.func = (pick < 30) ? OP_GET : (pick < 65) ? OP_SET : (pick < 95) ? OP_VERIFY : OP_UNUSED;
      c.space = 2'($urandom_range(3, 0));
      pick = $urandom_range(99, 0);
      if (c.space == SP_REGISTER) begin
         if (pick < 85)
            c.addr = 12'($urandom_range(8, 1));
         else if (pick < 95)
            c.addr = ($urandom_range(1, 0) != 0) ? 12'd0 : 12'($urandom_range(15, 9));
         else
            c.addr = 12'($urandom_range(4095, 0));
      end else begin
         if (pick < 45)
            c.addr = 12'($urandom_range(40, 0));
         else if (pick < 60)
            c.addr = 12'($urandom_range(MAX_CV, MAX_CV - 8));
         else if (pick < 80)
            c.addr = 12'($urandom_range(MAX_CV, 0));
         else
            c.addr = 12'($urandom_range(4095, MAX_CV + 1));
      end
      c.bit_pos = ($urandom_range(99, 0) < 88) ? 4'($urandom_range(7, 0))
                                                : 4'($urandom_range(15, 8));
      pick = $urandom_range(99, 0);
      if (c.func == OP_VERIFY && pick < 65)
         c.data = cell_value(PLAN_COPY, c);
      else if (c.space == SP_BIT && pick < 85)
         c.data = 8'($urandom_range(1, 0));
      else
         c.data = 8'($urandom_range(255, 0));
      return c;
   endfunction

   // Stimulus plan, end of run and verdict.
   initial begin
      command_type c;
      for (int i = 0; i <= MAX_CV; i++) begin
         cv_mem[PLAN_COPY][i] = '0;
         cv_mem[CHECK_COPY][i] = '0;
      end
      page_reg[PLAN_COPY] = 8'd1;
      page_reg[CHECK_COPY] = 8'd1;

      // Directed part: field extremes, every mode and each corner of the map.
      plan(OP_GET,    SP_CV,       12'd0,    4'd0,  8'h00);
      plan(OP_SET,    SP_CV,       12'd2048, 4'd0,  8'hFF);
      plan(OP_GET,    SP_CV,       12'd2048, 4'd0,  8'h00);
      plan(OP_SET,    SP_CV,       12'd4095, 4'd0,  8'h11);
      plan(OP_GET,    SP_PAGE,     12'd2049, 4'd0,  8'h00);
      plan(OP_SET,    SP_PAGE,     12'd3,    4'd0,  8'hA5);
      plan(OP_VERIFY, SP_CV,       12'd3,    4'd0,  8'hA5);
      plan(OP_VERIFY, SP_CV,       12'd3,    4'd0,  8'h5A);
      plan(OP_GET,    SP_REGISTER, REG_PAGE, 4'd0,  8'h00);
      plan(OP_SET,    SP_REGISTER, REG_PAGE, 4'd0,  8'h37);
      plan(OP_GET,    SP_REGISTER, REG_PAGE, 4'd0,  8'h00);
      plan(OP_GET,    SP_REGISTER, 12'd3,    4'd0,  8'h00);
      plan(OP_VERIFY, SP_REGISTER, REG_PAGE, 4'd0,  8'h01);
      plan(OP_SET,    SP_REGISTER, REG_CONFIG, 4'd0, 8'h0E);
      plan(OP_GET,    SP_CV,       12'd29,   4'd0,  8'h00);
      plan(OP_GET,    SP_REGISTER, 12'd0,    4'd0,  8'h00);
      plan(OP_SET,    SP_REGISTER, 12'd9,    4'd0,  8'h44);
      plan(OP_VERIFY, SP_REGISTER, 12'd4095, 4'd15, 8'hFF);
      plan(OP_SET,    SP_REGISTER, REG_LAST, 4'd0,  8'hC3);
      plan(OP_SET,    SP_BIT,      12'd3,    4'd7,  8'h00);
      plan(OP_GET,    SP_BIT,      12'd3,    4'd0,  8'h00);
      plan(OP_SET,    SP_BIT,      12'd3,    4'd1,  8'h02);
      plan(OP_VERIFY, SP_BIT,      12'd3,    4'd2,  8'h03);
      plan(OP_GET,    SP_BIT,      12'd2048, 4'd8,  8'h00);
      plan(OP_GET,    SP_CV,       12'd3,    4'd15, 8'h00);
      plan(OP_UNUSED, SP_CV,       12'd3,    4'd0,  8'h7F);
      directed_total = pending_cmds.size();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         c = random_command();
         plan(c.func, c.space, c.addr, c.bit_pos, c.data);
      end
      items_total = pending_cmds.size();

      @(negedge reset);
      while (pending_cmds.size() != 0 || expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d directed) over register, page, cv and bit modes.",
               accepted_count, directed_total);
      $display("Checked %0d results, %0d of them reporting a failure.",
               answer_count, failed_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Driver: predicts on each accepted transfer, then offers the next command or idles.
   always @(posedge clock) begin : drive
      command_type c;
      answer_type  a;
      int          idle_pct;
      logic        taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            c = pending_cmds.pop_front();
            a = execute_command(CHECK_COPY, c);
            expected_answers.push_back(a);
            accepted_count++;
         end
         if (!(start && !taken)) begin
            if (accepted_count < items_total / 3)
               idle_pct = 25;
            else if (accepted_count < 2 * items_total / 3)
               idle_pct = 69;
            else
               idle_pct = 0;
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
               c = pending_cmds[0];
               start <= 1'b1;
               req_func <= c.func;
               req_space <= c.space;
               req_cv_address <= c.addr;
               req_bit_index <= c.bit_pos;
               req_data_value <= c.data;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed result is matched against the oldest expected answer.
   always @(posedge clock) begin : observe
      answer_type a;
      if (!reset && rsp_valid) begin
         answer_count++;
         if (rsp_failed)
            failed_count++;
         if (expected_answers.size() == 0) begin
            $error("unexpected result: read_value %0h failed %0b", rsp_read_value, rsp_failed);
            error_count++;
         end else begin
            a = expected_answers.pop_front();
            if (rsp_read_value !== a.value) begin
               $error("read_value: expected %0h, got %0h", a.value, rsp_read_value);
               error_count++;
            end
            if (rsp_failed !== a.failed) begin
               $error("failed: expected %0b, got %0b", a.failed, rsp_failed);
               error_count++;
            end
         end
      end
   end

   // Watchdog covering the clearing pass and every request at the slowest pace.
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
